/* sv/fbfla_pkg.sv */
`default_nettype none

package fbfla_pkg;

  localparam int POOL_BYTES = 4096;
  localparam int MAX_BLOCKS = 256;
  // pool size rounded up to a power of two
  localparam int POOL_SPAN  = 1 << $clog2(POOL_BYTES);

  localparam int ADDR_W = 32;
  localparam int BSU_W  = 9;
  localparam int BSZ_W  = BSU_W + 4;
  localparam int HDL_W  = $clog2(MAX_BLOCKS);
  localparam int LNK_W  = HDL_W + 1;
  localparam int QUO_W  = 9;
  localparam int CNT_W  = $clog2(QUO_W);
  localparam int DSR_W  = BSZ_W + QUO_W - 1;
  localparam int PROD_W = HDL_W + BSZ_W;
  localparam int CNT_BLK_W = 9;
  localparam int STAT_W = 3;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  localparam logic [LNK_W-1:0] END_MARK = LNK_W'(MAX_BLOCKS);

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_NULL  = 3'd2,
    ST_RANGE = 3'd3,
    ST_NOFIT = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_RES_NULL,
    OP_RES_RANGE,
    OP_RES_EMPTY,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_ALLOC_RD,
    OP_ALLOC_DONE,
    OP_FREE_DONE,
    OP_INIT_FAIL,
    OP_INIT_SET,
    OP_LINK_STEP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_init;
    logic is_null;
    logic bad_base;
    logic bsz_zero;
    logic empty;
    logic div_last;
    logic free_reject;
    logic n_zero;
    logic link_last;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

/* sv/fbfla_if.sv */
`default_nettype none

interface fbfla_req_if import fbfla_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [ADDR_W-1:0] block_address;
  logic              null_pointer;

  modport source (output valid, command, block_address, null_pointer, input ready);
  modport sink   (input valid, command, block_address, null_pointer, output ready);
endinterface

interface fbfla_rsp_if import fbfla_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [ADDR_W-1:0]    granted_address;
  logic [HDL_W-1:0]     granted_handle;
  logic [CNT_BLK_W-1:0] free_blocks;

  modport source (output valid, status, granted_address, granted_handle, free_blocks,
                  input ready);
  modport sink   (input valid, status, granted_address, granted_handle, free_blocks,
                  output ready);
endinterface

interface fbfla_cfg_if import fbfla_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

`default_nettype wire

/* sv/fbfla_ram.sv */
`default_nettype none

module fbfla_ram #(
  parameter int Width = 9,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/fbfla_dp.sv */
`default_nettype none

module fbfla_dp import fbfla_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [1:0]           req_command_i,
  input  wire logic [ADDR_W-1:0]    req_block_address_i,
  input  wire logic                 req_null_pointer_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  input  wire dp_cmd_t              cmd_i,
  output dp_sts_t                   sts_o,
  output logic                      ram_we_o,
  output logic [HDL_W-1:0]          ram_waddr_o,
  output logic [LNK_W-1:0]          ram_wdata_o,
  output logic                      ram_re_o,
  output logic [HDL_W-1:0]          ram_raddr_o,
  input  wire logic [LNK_W-1:0]     ram_rdata_i,
  output logic                      rsp_valid_o,
  input  wire logic                 rsp_ready_i,
  output logic [STAT_W-1:0]         rsp_status_o,
  output logic [ADDR_W-1:0]         rsp_granted_address_o,
  output logic [HDL_W-1:0]          rsp_granted_handle_o,
  output logic [CNT_BLK_W-1:0]      rsp_free_blocks_o
);

  // control state, set by reset (block size to one unit, the rest to zero)
  logic [BSU_W-1:0]     bsu_q, bsu_d;
  logic [ADDR_W-1:0]    base_q, base_d;
  logic [LNK_W-1:0]     head_q, head_d;
  logic [CNT_BLK_W-1:0] free_q, free_d;
  logic [CNT_BLK_W-1:0] blk_q, blk_d;
  logic                 out_vld_q, out_vld_d;

  // payload and work registers
  cmd_e                 cmd_q;
  logic [ADDR_W-1:0]    addr_q;
  logic                 null_q;
  logic [ADDR_W-1:0]    rem_q, rem_d;
  logic [DSR_W-1:0]     dsr_q, dsr_d;
  logic [QUO_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [LNK_W-1:0]     lnk_q, lnk_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  status_e              res_st_q, res_st_d;
  logic [ADDR_W-1:0]    res_addr_q, res_addr_d;
  logic [HDL_W-1:0]     res_hdl_q, res_hdl_d;

  logic [BSZ_W-1:0]     bsz;
  logic [ADDR_W-1:0]    off;
  logic [ADDR_W-1:0]    dvd;
  logic [ADDR_W-1:0]    dsr_ext;
  logic                 div_ge;
  logic [CNT_BLK_W-1:0] n_sel;
  logic [LNK_W-1:0]     lnk_nxt;
  logic                 is_init;

  assign bsz     = {bsu_q, 4'b0000};
  assign off     = addr_q - base_q;
  assign is_init = (cmd_q == CMD_INIT);
  assign dvd     = is_init ? ADDR_W'(POOL_SPAN) : off;
  assign dsr_ext = ADDR_W'(dsr_q);
  assign div_ge  = rem_q >= dsr_ext;
  assign lnk_nxt = lnk_q + 1'b1;

  // block count from the quotient, capped at the link store depth
  always_comb begin
    if (ovf_q || (quo_q > CNT_BLK_W'(MAX_BLOCKS))) begin
      n_sel = CNT_BLK_W'(MAX_BLOCKS);
    end else begin
      n_sel = quo_q;
    end
  end

  always_comb begin
    sts_o.is_init     = is_init;
    sts_o.is_null     = null_q;
    sts_o.bsz_zero    = (bsu_q == '0);
    sts_o.bad_base    = (bsu_q == '0) || (addr_q < base_q);
    sts_o.empty       = (free_q == '0) || (head_q >= END_MARK);
    sts_o.div_last    = (cnt_q == CNT_W'(QUO_W - 1));
    sts_o.free_reject = ovf_q || (quo_q >= blk_q);
    sts_o.n_zero      = (n_sel == '0);
    sts_o.link_last   = (lnk_nxt == blk_q);
    sts_o.out_busy    = out_vld_q && !rsp_ready_i;
  end

  assign ram_we_o    = (cmd_i.op == OP_LINK_STEP) || (cmd_i.op == OP_FREE_DONE);
  assign ram_waddr_o = (cmd_i.op == OP_LINK_STEP) ? lnk_q[HDL_W-1:0] : quo_q[HDL_W-1:0];
  assign ram_re_o    = (cmd_i.op == OP_ALLOC_RD);
  assign ram_raddr_o = head_q[HDL_W-1:0];

  always_comb begin
    if (cmd_i.op == OP_LINK_STEP) begin
      ram_wdata_o = sts_o.link_last ? END_MARK : lnk_nxt;
    end else begin
      ram_wdata_o = head_q;
    end
  end

  always_comb begin
    bsu_d      = bsu_q;
    base_d     = base_q;
    head_d     = head_q;
    free_d     = free_q;
    blk_d      = blk_q;
    out_vld_d  = out_vld_q;
    rem_d      = rem_q;
    dsr_d      = dsr_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    lnk_d      = lnk_q;
    prod_d     = prod_q;
    res_st_d   = res_st_q;
    res_addr_d = res_addr_q;
    res_hdl_d  = res_hdl_q;

    if (cfg_we_i) begin
      if (cfg_index_i == CFG_BLOCK_SIZE) begin
        bsu_d = cfg_data_i[BSU_W-1:0];
      end else if (cfg_index_i == CFG_POOL_BASE) begin
        base_d = cfg_data_i[ADDR_W-1:0];
      end
    end

    case (cmd_i.op)
      OP_CAPTURE: begin
        res_st_d   = ST_OK;
        res_addr_d = '0;
        res_hdl_d  = '0;
      end
      OP_RES_NULL:  res_st_d = ST_NULL;
      OP_RES_RANGE: res_st_d = ST_RANGE;
      OP_RES_EMPTY: res_st_d = ST_EMPTY;
      OP_DIV_START: begin
        rem_d = dvd;
        dsr_d = {bsz, {(QUO_W-1){1'b0}}};
        quo_d = '0;
        cnt_d = '0;
        ovf_d = dvd >= ADDR_W'({bsz, {QUO_W{1'b0}}});
      end
      OP_DIV_STEP: begin
        if (div_ge) begin
          rem_d = rem_q - dsr_ext;
        end
        quo_d = {quo_q[QUO_W-2:0], div_ge};
        dsr_d = dsr_q >> 1;
        cnt_d = cnt_q + 1'b1;
      end
      OP_ALLOC_RD: begin
        prod_d = PROD_W'(head_q[HDL_W-1:0]) * PROD_W'(bsz);
      end
      OP_ALLOC_DONE: begin
        head_d     = ram_rdata_i;
        free_d     = free_q - 1'b1;
        res_addr_d = base_q + ADDR_W'(prod_q);
        res_hdl_d  = head_q[HDL_W-1:0];
      end
      OP_FREE_DONE: begin
        head_d    = quo_q;
        res_hdl_d = quo_q[HDL_W-1:0];
        if (free_q < blk_q) begin
          free_d = free_q + 1'b1;
        end
      end
      OP_INIT_FAIL: begin
        blk_d    = '0;
        free_d   = '0;
        head_d   = END_MARK;
        res_st_d = ST_NOFIT;
      end
      OP_INIT_SET: begin
        blk_d = n_sel;
        lnk_d = '0;
      end
      OP_LINK_STEP: begin
        lnk_d = lnk_nxt;
        if (sts_o.link_last) begin
          head_d = '0;
          free_d = blk_q;
        end
      end
      default: ;
    endcase

    if (cmd_i.out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsu_q     <= BSU_W'(1);
      base_q    <= '0;
      head_q    <= '0;
      free_q    <= '0;
      blk_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      bsu_q     <= bsu_d;
      base_q    <= base_d;
      head_q    <= head_d;
      free_q    <= free_d;
      blk_q     <= blk_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CAPTURE) begin
      cmd_q  <= cmd_e'(req_command_i);
      addr_q <= req_block_address_i;
      null_q <= req_null_pointer_i;
    end
    rem_q      <= rem_d;
    dsr_q      <= dsr_d;
    quo_q      <= quo_d;
    cnt_q      <= cnt_d;
    ovf_q      <= ovf_d;
    lnk_q      <= lnk_d;
    prod_q     <= prod_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
    res_hdl_q  <= res_hdl_d;
    if (cmd_i.out_load) begin
      rsp_status_o          <= res_st_q;
      rsp_granted_address_o <= res_addr_q;
      rsp_granted_handle_o  <= res_hdl_q;
      rsp_free_blocks_o     <= free_q;
    end
  end

  assign rsp_valid_o = out_vld_q;

endmodule

`default_nettype wire

/* sv/fbfla_ctrl.sv */
`default_nettype none

module fbfla_ctrl import fbfla_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       req_valid_i,
  input  wire logic [1:0] req_command_i,
  output logic            req_ready_o,
  input  wire dp_sts_t    sts_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE       = 10'b00_0000_0001,
    S_ALLOC      = 10'b00_0000_0010,
    S_ALLOC_WAIT = 10'b00_0000_0100,
    S_FREE_CHK   = 10'b00_0000_1000,
    S_INIT_CHK   = 10'b00_0001_0000,
    S_DIV        = 10'b00_0010_0000,
    S_FREE_END   = 10'b00_0100_0000,
    S_INIT_END   = 10'b00_1000_0000,
    S_LINK       = 10'b01_0000_0000,
    S_FIN        = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    req_ready_o  = 1'b0;
    cmd_o.op     = OP_NONE;
    cmd_o.out_load = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          case (cmd_e'(req_command_i))
            CMD_ALLOC: state_d = S_ALLOC;
            CMD_FREE:  state_d = S_FREE_CHK;
            CMD_INIT:  state_d = S_INIT_CHK;
            default:   state_d = S_FIN;
          endcase
        end
      end
      S_ALLOC: begin
        if (sts_i.empty) begin
          cmd_o.op = OP_RES_EMPTY;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = OP_ALLOC_RD;
          state_d  = S_ALLOC_WAIT;
        end
      end
      S_ALLOC_WAIT: begin
        cmd_o.op = OP_ALLOC_DONE;
        state_d  = S_FIN;
      end
      S_FREE_CHK: begin
        if (sts_i.is_null) begin
          cmd_o.op = OP_RES_NULL;
          state_d  = S_FIN;
        end else if (sts_i.bad_base) begin
          cmd_o.op = OP_RES_RANGE;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = OP_DIV_START;
          state_d  = S_DIV;
        end
      end
      S_INIT_CHK: begin
        if (sts_i.bsz_zero) begin
          cmd_o.op = OP_INIT_FAIL;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = OP_DIV_START;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (sts_i.div_last) begin
          state_d = sts_i.is_init ? S_INIT_END : S_FREE_END;
        end
      end
      S_FREE_END: begin
        cmd_o.op = sts_i.free_reject ? OP_RES_RANGE : OP_FREE_DONE;
        state_d  = S_FIN;
      end
      S_INIT_END: begin
        if (sts_i.n_zero) begin
          cmd_o.op = OP_INIT_FAIL;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = OP_INIT_SET;
          state_d  = S_LINK;
        end
      end
      S_LINK: begin
        cmd_o.op = OP_LINK_STEP;
        if (sts_i.link_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* sv/fixed_block_free_list_allocator_top.sv */
// Fixed-size block pool allocator with a linked free list of block handles.
// Channels: req_i (command, block_address, null_pointer), rsp_o (status,
// granted_address, granted_handle, free_blocks) and cfg_i (reg_index,
// reg_data; index 0 block size in 16-byte units, index 1 pool base). Each
// channel moves one transfer when valid and ready are high at a clock edge.
// Every request gives exactly one response. cfg_i is always ready; write it
// only while no request is in flight.
// One request is worked at a time. Free and initialize run a shared
// 9-step shift-subtract divider (one quotient bit a cycle); initialize
// also sweeps the link store, one entry a cycle; allocate reads the link
// store for the next free-list head. An empty allocate, a null or
// below-base free and an initialize with zero block size answer without
// the divider or the link store.
// A new request is taken once the previous result sits in the output
// register, even if the receiver has not yet taken it; if the receiver
// stalls, the next result waits until the output register frees up.
// Reset empties the free list (count zero, no blocks), sets block size to
// one unit and base to zero; the link store holds no defined contents
// until an initialize writes it.
`default_nettype none

module fixed_block_free_list_allocator_top import fbfla_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fbfla_req_if.sink   req_i,
  fbfla_rsp_if.source rsp_o,
  fbfla_cfg_if.sink   cfg_i
);

  dp_cmd_t          dp_cmd;
  dp_sts_t          dp_sts;
  logic             ram_we;
  logic [HDL_W-1:0] ram_waddr;
  logic [LNK_W-1:0] ram_wdata;
  logic             ram_re;
  logic [HDL_W-1:0] ram_raddr;
  logic [LNK_W-1:0] ram_rdata;

  assign cfg_i.ready = 1'b1;

  fbfla_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_command_i (req_i.command),
    .req_ready_o   (req_i.ready),
    .sts_i         (dp_sts),
    .cmd_o         (dp_cmd)
  );

  fbfla_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .req_command_i         (req_i.command),
    .req_block_address_i   (req_i.block_address),
    .req_null_pointer_i    (req_i.null_pointer),
    .cfg_we_i              (cfg_i.valid & cfg_i.ready),
    .cfg_index_i           (cfg_i.reg_index),
    .cfg_data_i            (cfg_i.reg_data),
    .cmd_i                 (dp_cmd),
    .sts_o                 (dp_sts),
    .ram_we_o              (ram_we),
    .ram_waddr_o           (ram_waddr),
    .ram_wdata_o           (ram_wdata),
    .ram_re_o              (ram_re),
    .ram_raddr_o           (ram_raddr),
    .ram_rdata_i           (ram_rdata),
    .rsp_valid_o           (rsp_o.valid),
    .rsp_ready_i           (rsp_o.ready),
    .rsp_status_o          (rsp_o.status),
    .rsp_granted_address_o (rsp_o.granted_address),
    .rsp_granted_handle_o  (rsp_o.granted_handle),
    .rsp_free_blocks_o     (rsp_o.free_blocks)
  );

  fbfla_ram #(
    .Width (LNK_W),
    .Depth (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

/* sv/fbfla_chk.sv */
`default_nettype none

module fbfla_chk import fbfla_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 req_valid_i,
  input wire logic                 req_ready_i,
  input wire logic                 rsp_valid_i,
  input wire logic                 rsp_ready_i,
  input wire logic [STAT_W-1:0]    rsp_status_i,
  input wire logic [ADDR_W-1:0]    rsp_granted_address_i,
  input wire logic [CNT_BLK_W-1:0] rsp_free_blocks_i
);

  // a stalled response stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in flight");

  a_addr_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_OK) |-> (rsp_granted_address_i == '0))
    else $error("address granted on a failed request");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_free_blocks_i <= CNT_BLK_W'(MAX_BLOCKS)))
    else $error("free count above store depth");

  a_nofit_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_NOFIT) |-> (rsp_free_blocks_i == '0))
    else $error("failed init left free blocks");

endmodule

bind fixed_block_free_list_allocator_top fbfla_chk u_fbfla_chk (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .req_valid_i           (req_i.valid),
  .req_ready_i           (req_i.ready),
  .rsp_valid_i           (rsp_o.valid),
  .rsp_ready_i           (rsp_o.ready),
  .rsp_status_i          (rsp_o.status),
  .rsp_granted_address_i (rsp_o.granted_address),
  .rsp_free_blocks_i     (rsp_o.free_blocks)
);

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench;
  import fbfla_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SEGMENTS    = 15;
  localparam int SEG_ITEMS   = 110;

  typedef struct {
    status_e              status;
    logic [ADDR_W-1:0]    addr;
    logic [HDL_W-1:0]     handle;
    logic [CNT_BLK_W-1:0] free_blocks;
  } pool_rsp_t;

  // Tracks the free list and the responses it implies, in transfer order.
  class pool_board;
    logic [BSU_W-1:0]     units;
    logic [ADDR_W-1:0]    base;
    logic [LNK_W-1:0]     links [MAX_BLOCKS];
    logic [LNK_W-1:0]     head;
    logic [CNT_BLK_W-1:0] free_cnt;
    logic [CNT_BLK_W-1:0] blk_cnt;
    pool_rsp_t            awaited[$];
    logic [ADDR_W-1:0]    held[$];
    int                   mismatches;
    int                   checked;
    int                   accepted;
    int                   seen [5];

    function new();
      units      = BSU_W'(1);
      base       = '0;
      head       = '0;
      free_cnt   = '0;
      blk_cnt    = '0;
      mismatches = 0;
      checked    = 0;
      accepted   = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx == CFG_BLOCK_SIZE) units = data[BSU_W-1:0];
      else if (idx == CFG_POOL_BASE) base = data;
      held.delete();
    endfunction

    function void note_request(cmd_e cmd, logic [ADDR_W-1:0] addr, logic nul);
      pool_rsp_t         r;
      logic [BSZ_W-1:0]  bsz;
      logic [ADDR_W-1:0] off;
      logic [ADDR_W-1:0] h;
      int                n;
      r.status = ST_OK;
      r.addr   = '0;
      r.handle = '0;
      bsz      = {units, 4'b0000};
      accepted++;
      case (cmd)
        CMD_INIT: begin
          held.delete();
          n = (bsz != 0) ? POOL_SPAN / int'(bsz) : 0;
          if (n == 0) begin
            blk_cnt  = '0;
            free_cnt = '0;
            head     = END_MARK;
            r.status = ST_NOFIT;
          end else begin
            if (n > MAX_BLOCKS) n = MAX_BLOCKS;
            blk_cnt = CNT_BLK_W'(n);
            for (int i = 0; i < n; i++)
              links[i] = (i + 1 < n) ? LNK_W'(i + 1) : END_MARK;
            head     = '0;
            free_cnt = blk_cnt;
          end
        end
        CMD_ALLOC: begin
          if (free_cnt == 0 || head >= END_MARK) begin
            r.status = ST_EMPTY;
          end else begin
            r.addr   = ADDR_W'(base + head * bsz);
            r.handle = head[HDL_W-1:0];
            held.push_back(r.addr);
            head     = links[head[HDL_W-1:0]];
            free_cnt = free_cnt - 1'b1;
          end
        end
        CMD_FREE: begin
          if (nul) begin
            r.status = ST_NULL;
          end else if (bsz == 0 || addr < base) begin
            r.status = ST_RANGE;
          end else begin
            off = addr - base;
            h   = off / bsz;
            if (h >= blk_cnt) begin
              r.status = ST_RANGE;
            end else begin
              links[h[HDL_W-1:0]] = head;
              head = LNK_W'(h);
              if (free_cnt < blk_cnt) free_cnt = free_cnt + 1'b1;
              r.handle = h[HDL_W-1:0];
            end
          end
        end
        default: ;
      endcase
      r.free_blocks = free_cnt;
      awaited.push_back(r);
    endfunction

    function void check_response(logic [STAT_W-1:0] st, logic [ADDR_W-1:0] addr,
                                 logic [HDL_W-1:0] handle, logic [CNT_BLK_W-1:0] fb);
      pool_rsp_t want;
      checked++;
      if (awaited.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected response: status %0d addr %h handle %0d free %0d",
                   st, addr, handle, fb);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (STAT_W'(want.status) !== st || want.addr !== addr ||
          want.handle !== handle || want.free_blocks !== fb) begin
        if (mismatches < 10)
          $display("mismatch: expected status %0d addr %h handle %0d free %0d, got status %0d addr %h handle %0d free %0d",
                   want.status, want.addr, want.handle, want.free_blocks,
                   st, addr, handle, fb);
        mismatches++;
      end else begin
        seen[st]++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  fbfla_req_if req_bus ();
  fbfla_rsp_if rsp_bus ();
  fbfla_cfg_if cfg_bus ();

  fixed_block_free_list_allocator_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  pool_board board;
  int        tx_idle_pct;
  int        rx_idle_pct;
  int        hold_cycles = 0;
  int        quiet_cycles = 0;
  int        cfg_writes = 0;

  always #6 clk = ~clk;

  task automatic send_request(cmd_e cmd, logic [ADDR_W-1:0] addr, logic nul);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    req_bus.valid         <= 1'b1;
    req_bus.command       <= cmd;
    req_bus.block_address <= addr;
    req_bus.null_pointer  <= nul;
    do @(posedge clk); while (!req_bus.ready);
    board.note_request(cmd, addr, nul);
  endtask

  // Sender holds off until every outstanding response is back.
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.reg_data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    board.set_reg(idx, data);
    cfg_writes++;
  endtask

  task automatic configure(logic [BSU_W-1:0] units, logic [ADDR_W-1:0] base);
    drain();
    write_reg(CFG_BLOCK_SIZE, CFG_DAT_W'(units));
    write_reg(CFG_POOL_BASE, base);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic pick_config(output logic [BSU_W-1:0] units, output logic [ADDR_W-1:0] base);
    case ($urandom_range(9))
      0:       units = BSU_W'(1);
      1:       units = BSU_W'(256);
      2:       units = '0;
      3:       units = '1;
      4:       units = BSU_W'($urandom_range(257, 510));
      5, 6:    units = BSU_W'($urandom_range(2, 16));
      default: units = BSU_W'($urandom_range(1, 256));
    endcase
    case ($urandom_range(5))
      0:       base = '0;
      1:       base = '1;
      2:       base = 32'hFFFF_F000 + $urandom_range(4095);
      default: base = $urandom;
    endcase
  endtask

  // Mostly allocate and give back real blocks; the rest is edge and noise traffic.
  task automatic pick_request(output cmd_e cmd, output logic [ADDR_W-1:0] addr,
                              output logic nul);
    int unsigned roll;
    int unsigned bsz;
    int          idx;
    roll = $urandom_range(99);
    bsz  = board.units * 16;
    addr = $urandom;
    nul  = 1'b0;
    cmd  = CMD_FREE;
    if (roll < 44) begin
      cmd = CMD_ALLOC;
      nul = ($urandom_range(7) == 0);
    end else if (roll < 80) begin
      if (board.held.size() != 0 && $urandom_range(9) != 0) begin
        idx  = $urandom_range(board.held.size() - 1);
        addr = board.held[idx];
        // occasionally leave it on the list for a double free later
        if ($urandom_range(15) != 0) board.held.delete(idx);
        if (bsz > 16 && $urandom_range(1) == 1) addr = addr + $urandom_range(bsz - 1);
      end else begin
        addr = board.base + $urandom_range(POOL_SPAN + 64);
      end
    end else if (roll < 85) begin
      nul = 1'b1;
    end else if (roll < 90) begin
      nul = 1'b0;
    end else if (roll < 93) begin
      addr = board.base - $urandom_range(1, 16);
    end else if (roll < 96) begin
      cmd = CMD_INIT;
    end else begin
      cmd = CMD_NOP;
      nul = $urandom_range(1);
    end
  endtask

  task automatic run_directed();
    // before any init: empty list, nothing in range
    send_request(CMD_ALLOC, '0, 1'b0);
    send_request(CMD_FREE, '0, 1'b0);
    send_request(CMD_FREE, 32'h0000_0040, 1'b1);
    send_request(CMD_NOP, '1, 1'b1);
    send_request(CMD_INIT, '0, 1'b0);
    send_request(CMD_ALLOC, '1, 1'b1);
    send_request(CMD_ALLOC, '0, 1'b0);
    send_request(CMD_FREE, 32'h0000_0018, 1'b0);
    send_request(CMD_FREE, 32'h0000_0010, 1'b0);
    send_request(CMD_FREE, 32'h0000_0010, 1'b0);
    send_request(CMD_FREE, '1, 1'b0);
    send_request(CMD_FREE, 32'h0000_0FFF, 1'b0);
    send_request(CMD_FREE, 32'h0000_1000, 1'b0);
    // zero block size
    configure('0, '0);
    send_request(CMD_INIT, '0, 1'b0);
    send_request(CMD_ALLOC, '0, 1'b0);
    send_request(CMD_FREE, 32'h0000_0020, 1'b0);
    // one block at the top of the address space
    configure(BSU_W'(256), 32'hFFFF_FFF0);
    send_request(CMD_INIT, '0, 1'b0);
    send_request(CMD_ALLOC, '0, 1'b0);
    send_request(CMD_ALLOC, '0, 1'b0);
    send_request(CMD_FREE, 32'hFFFF_FFFF, 1'b0);
    send_request(CMD_FREE, 32'hFFFF_FFEF, 1'b0);
    // block too big for the pool
    configure('1, 32'h8000_0000);
    send_request(CMD_INIT, '0, 1'b0);
    send_request(CMD_ALLOC, '0, 1'b0);
    configure(BSU_W'(3), 32'h0000_1234);
    send_request(CMD_INIT, '0, 1'b0);
  endtask

  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rsp_bus.ready <= 1'b0;
        hold_cycles--;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_bus.valid && rsp_bus.ready)
      board.check_response(rsp_bus.status, rsp_bus.granted_address,
                           rsp_bus.granted_handle, rsp_bus.free_blocks);
  end

  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [BSU_W-1:0]  seg_units;
    logic [ADDR_W-1:0] seg_base;
    cmd_e              cmd;
    logic [ADDR_W-1:0] addr;
    logic              nul;
    board = new();
    tx_idle_pct = 19;
    rx_idle_pct = 79;
    rst_n                 <= 1'b0;
    req_bus.valid         <= 1'b0;
    req_bus.command       <= CMD_ALLOC;
    req_bus.block_address <= '0;
    req_bus.null_pointer  <= 1'b0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.reg_index     <= CFG_BLOCK_SIZE;
    cfg_bus.reg_data      <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == SEGMENTS / 3) begin
        tx_idle_pct = 79;
        rx_idle_pct = 19;
      end
      if (seg == 2 * SEGMENTS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick_config(seg_units, seg_base);
      configure(seg_units, seg_base);
      send_request(CMD_INIT, $urandom, 1'b0);
      // long receiver stall while requests keep coming: the block backs up
      if (seg == 2 * SEGMENTS / 3 + 1) hold_cycles = 300;
      repeat (SEG_ITEMS) begin
        pick_request(cmd, addr, nul);
        send_request(cmd, addr, nul);
      end
    end

    drain();
    repeat (300) @(posedge clk);

    $display("covered %0d requests, %0d responses checked, %0d register writes",
             board.accepted, board.checked, cfg_writes);
    $display("status mix: ok %0d, empty %0d, null %0d, range %0d, no fit %0d",
             board.seen[ST_OK], board.seen[ST_EMPTY], board.seen[ST_NULL],
             board.seen[ST_RANGE], board.seen[ST_NOFIT]);
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
